// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is high
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ----- hw/rtl/mac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mac_pkg;

   // default stored line length, including the byte that would overflow it
   localparam int LineLenDefault = 32;

   // event kinds on the request channel
   localparam logic [1:0] CmdByte   = 2'd0;
   localparam logic [1:0] CmdTick   = 2'd1;
   localparam logic [1:0] CmdButton = 2'd2;

   // register indexes on the csr channel
   localparam logic [1:0] CsrTimeout   = 2'd0;
   localparam logic [1:0] CsrTelemetry = 2'd1;
   localparam logic [1:0] CsrThrMin    = 2'd2;
   localparam logic [1:0] CsrThrMax    = 2'd3;

   // characters the line parser looks at
   localparam logic [7:0] ChA     = 8'h41;
   localparam logic [7:0] ChD     = 8'h44;
   localparam logic [7:0] ChS     = 8'h53;
   localparam logic [7:0] ChR     = 8'h52;
   localparam logic [7:0] ChNl    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;

   // reset values and saturation limits
   localparam logic [15:0] TimeoutReset   = 16'd500;
   localparam logic [15:0] TelemetryReset = 16'd100;
   localparam logic [10:0] ThrMinReset    = 11'd1000;
   localparam logic [10:0] ThrMaxReset    = 11'd2000;
   localparam logic [10:0] ThrottleReset  = 11'd1000;
   localparam logic [10:0] ThrottleSat    = 11'd2047;
   localparam logic [15:0] CountSat       = 16'hFFFF;

   typedef enum logic [2:0] {
      EvArmed     = 3'd0,
      EvDisarmed  = 3'd1,
      EvKilled    = 3'd2,
      EvTimeout   = 3'd3,
      EvTelemetry = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      ModeDisarmed = 2'd0,
      ModeArmed    = 2'd1,
      ModeKilled   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PhaseBlank  = 2'd0,
      PhaseDigits = 2'd1,
      PhaseIgnore = 2'd2
   } phase_type;

   // all results caused by one request word, sharing the state after it
   typedef struct packed {
      logic [1:0]      count;
      event_type [2:0] codes;
      logic [10:0]     pulse_width;
      mode_type        mode;
      logic            drive_enable;
   } grp_type;

   // raise to min, then cut to max, so max wins when the two cross
   function automatic logic [10:0] thr_clamp(input logic [10:0] v, input logic [10:0] lo,
                                             input logic [10:0] hi);
      logic [10:0] t;
      t = (v < lo) ? lo : v;
      return (t > hi) ? hi : t;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mac_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// request channel: one event word
interface mac_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// response channel: one result word
interface mac_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_code;
   logic [10:0] pulse_width;
   logic [1:0]  mode;
   logic        drive_enable;
   logic        last_of_run;

   modport source (output valid, output event_code, output pulse_width, output mode,
                   output drive_enable, output last_of_run, input ready);
   modport sink   (input valid, input event_code, input pulse_width, input mode,
                   input drive_enable, input last_of_run, output ready);
endinterface

// register write channel
interface mac_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mac_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mac_ctrl
   import mac_pkg::*;
#(
   parameter int LINE_LEN = LineLenDefault
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mac_req_if.sink    req_bus,
   mac_csr_if.sink    csr_bus,
   output grp_type    grp_word,
   output logic       grp_push,
   input  wire logic  grp_space
);

   localparam int PosW = $clog2(LINE_LEN);
   localparam logic [PosW-1:0] PosLast = PosW'(LINE_LEN - 1);

   // settings
   logic [15:0] timeout_ff;
   logic [15:0] period_ff;
   logic [10:0] thrmin_ff;
   logic [10:0] thrmax_ff;

   // drive and parser state
   mode_type    mode_ff, mode_in;
   logic [10:0] thr_ff, thr_in;
   logic        en_ff, en_in;
   logic [15:0] sil_ff, sil_in;
   logic [15:0] tel_ff, tel_in;
   logic [PosW-1:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  letter_ff, letter_in;
   logic [10:0] accum_ff, accum_in;

   logic            accept;
   logic [10:0]     thr_idle;
   logic [14:0]     acc_wide;
   logic [15:0]     sil_inc;
   logic [15:0]     tel_inc;
   logic            timed_out;
   logic            telem_due;
   logic [1:0]      count_c;
   event_type [2:0] codes_c;

   assign req_bus.ready = grp_space;
   assign csr_bus.ready = 1'b1;
   assign accept = req_bus.valid && req_bus.ready;
   assign thr_idle = thr_clamp(thrmin_ff, thrmin_ff, thrmax_ff);

   // settings writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TimeoutReset;
         period_ff  <= TelemetryReset;
         thrmin_ff  <= ThrMinReset;
         thrmax_ff  <= ThrMaxReset;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CsrTimeout:   timeout_ff <= csr_bus.data;
            CsrTelemetry: period_ff  <= csr_bus.data;
            CsrThrMin:    thrmin_ff  <= csr_bus.data[10:0];
            CsrThrMax:    thrmax_ff  <= csr_bus.data[10:0];
            default:      ;
         endcase
      end
   end

   // event handling for one accepted word
   always_comb begin
      mode_in   = mode_ff;
      thr_in    = thr_ff;
      en_in     = en_ff;
      sil_in    = sil_ff;
      tel_in    = tel_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      letter_in = letter_ff;
      accum_in  = accum_ff;
      timed_out = 1'b0;
      telem_due = 1'b0;
      count_c   = 2'd0;
      codes_c[0] = EvArmed;
      codes_c[1] = EvArmed;
      codes_c[2] = EvArmed;
      acc_wide  = 15'(accum_ff) * 15'd10 + {11'd0, req_bus.rx_byte[3:0]};
      sil_inc   = (sil_ff == CountSat) ? sil_ff : sil_ff + 16'd1;
      tel_inc   = (tel_ff == CountSat) ? tel_ff : tel_ff + 16'd1;
      if (accept) begin
         case (req_bus.cmd)
            CmdByte: begin
               if (req_bus.rx_byte == ChNl) begin
                  // end of line: run the command
                  if (phase_ff != PhaseBlank) begin
                     case (letter_ff)
                        ChA: begin
                           if (mode_ff != ModeKilled) begin
                              mode_in    = ModeArmed;
                              sil_in     = '0;
                              thr_in     = thr_idle;
                              codes_c[0] = EvArmed;
                              count_c    = 2'd1;
                           end
                        end
                        ChD: begin
                           mode_in    = ModeDisarmed;
                           thr_in     = thr_idle;
                           codes_c[0] = EvDisarmed;
                           count_c    = 2'd1;
                        end
                        ChS: begin
                           if (mode_ff == ModeArmed) begin
                              thr_in = thr_clamp(accum_ff, thrmin_ff, thrmax_ff);
                              sil_in = '0;
                           end
                        end
                        ChR: begin
                           if (mode_ff == ModeKilled) begin
                              en_in      = 1'b1;
                              mode_in    = ModeDisarmed;
                              thr_in     = thr_idle;
                              codes_c[0] = EvDisarmed;
                              count_c    = 2'd1;
                           end
                        end
                        default: ;
                     endcase
                  end
                  pos_in    = '0;
                  phase_in  = PhaseBlank;
                  letter_in = '0;
                  accum_in  = '0;
               end else if (pos_ff >= PosLast) begin
                  // line overflow: start again empty
                  pos_in    = '0;
                  phase_in  = PhaseBlank;
                  letter_in = '0;
                  accum_in  = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  case (phase_ff)
                     PhaseBlank: begin
                        if (!(req_bus.rx_byte == ChSpace || req_bus.rx_byte == ChCr)) begin
                           letter_in = req_bus.rx_byte;
                           phase_in  = (req_bus.rx_byte == ChS) ? PhaseDigits : PhaseIgnore;
                        end
                     end
                     PhaseDigits: begin
                        if (req_bus.rx_byte inside {[ChZero:ChNine]}) begin
                           accum_in = (acc_wide > 15'(ThrottleSat)) ? ThrottleSat
                                                                     : acc_wide[10:0];
                        end else begin
                           phase_in = PhaseIgnore;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            CmdTick: begin
               // silence watchdog while armed
               if (mode_ff == ModeArmed) begin
                  sil_in = sil_inc;
                  if (sil_inc > timeout_ff) begin
                     mode_in   = ModeDisarmed;
                     thr_in    = thr_idle;
                     timed_out = 1'b1;
                  end
               end
               // telemetry period
               tel_in = tel_inc;
               if (tel_inc >= period_ff) begin
                  tel_in    = '0;
                  telem_due = 1'b1;
               end
               if (timed_out) begin
                  codes_c[0] = EvDisarmed;
                  codes_c[1] = EvTimeout;
                  codes_c[2] = EvTelemetry;
                  count_c    = telem_due ? 2'd3 : 2'd2;
               end else begin
                  codes_c[0] = EvTelemetry;
                  count_c    = telem_due ? 2'd1 : 2'd0;
               end
            end
            CmdButton: begin
               thr_in     = thr_idle;
               count_c    = 2'd1;
               if (mode_ff == ModeKilled) begin
                  en_in      = 1'b1;
                  mode_in    = ModeDisarmed;
                  codes_c[0] = EvDisarmed;
               end else begin
                  en_in      = 1'b0;
                  mode_in    = ModeKilled;
                  codes_c[0] = EvKilled;
               end
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeDisarmed;
         thr_ff    <= ThrottleReset;
         en_ff     <= 1'b1;
         sil_ff    <= '0;
         tel_ff    <= '0;
         pos_ff    <= '0;
         phase_ff  <= PhaseBlank;
         letter_ff <= '0;
         accum_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         thr_ff    <= thr_in;
         en_ff     <= en_in;
         sil_ff    <= sil_in;
         tel_ff    <= tel_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         letter_ff <= letter_in;
         accum_ff  <= accum_in;
      end
   end

   // result group towards the queue
   assign grp_push             = accept && (count_c != 2'd0);
   assign grp_word.count        = count_c;
   assign grp_word.codes        = codes_c;
   assign grp_word.pulse_width  = thr_in;
   assign grp_word.mode         = mode_in;
   assign grp_word.drive_enable = en_in;

endmodule

`default_nettype wire

// ----- hw/rtl/mac_rsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mac_rsp_queue
   import mac_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire grp_type  grp_word,
   input  wire logic     grp_push,
   output logic          grp_space,
   mac_rsp_if.source     rsp_bus
);

   localparam logic [1:0] GrpDepth = 2'd2;

   grp_type    ent_ff [2];
   logic [0:0] wr_ptr_ff, wr_ptr_in;
   logic [0:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] sub_ff, sub_in;

   grp_type head;
   logic    last;
   logic    word_take;
   logic    grp_pop;

   assign head      = ent_ff[rd_ptr_ff];
   assign last      = (sub_ff == head.count - 2'd1);
   assign word_take = rsp_bus.valid && rsp_bus.ready;
   assign grp_pop   = word_take && last;
   assign grp_space = (cnt_ff != GrpDepth);

   // result word from the head group
   assign rsp_bus.valid        = (cnt_ff != 2'd0);
   assign rsp_bus.event_code   = head.codes[sub_ff];
   assign rsp_bus.pulse_width  = head.pulse_width;
   assign rsp_bus.mode         = head.mode;
   assign rsp_bus.drive_enable = head.drive_enable;
   assign rsp_bus.last_of_run  = last;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = grp_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = grp_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      case ({grp_push, grp_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
      sub_in = sub_ff;
      if (word_take) begin
         sub_in = last ? 2'd0 : sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         sub_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         sub_ff    <= sub_in;
      end
   end

   // group storage
   always_ff @(posedge clock) begin
      if (grp_push) begin
         ent_ff[wr_ptr_ff] <= grp_word;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/motor_arming_command_controller_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Motor arming controller: parses command lines, runs the silence watchdog
// and telemetry timer, and handles the kill button.
// req_bus carries one event word (serial byte, millisecond tick or button
// press); rsp_bus carries result words, zero to three per event, the last of
// them flagged with last_of_run; csr_bus writes the four settings and is
// always ready.
// An event word is taken and all of its state updates are registered together;
// its first result word shows on rsp_bus once earlier result groups have left.
// Events are taken at one per cycle while the queue has space; results leave at
// one per cycle while the receiver is ready, so the sustained rate is bounded by
// the result count of the events (three for a timeout tick with telemetry).
// A two-group result queue separates the sides: req_bus.ready falls exactly
// when both groups are occupied.
// Reset (synchronous) restores the default settings, disarms with enable
// high and idle throttle, clears the timers and the line, and empties the
// result queue.

module motor_arming_command_controller_core
   import mac_pkg::*;
#(
   parameter int LINE_LEN = LineLenDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   mac_req_if.sink   req_bus,
   mac_rsp_if.source rsp_bus,
   mac_csr_if.sink   csr_bus
);

   grp_type grp_word;
   logic    grp_push;
   logic    grp_space;

   // event processing and settings
   mac_ctrl #(
      .LINE_LEN(LINE_LEN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .grp_word  (grp_word),
      .grp_push  (grp_push),
      .grp_space (grp_space)
   );

   // result queue and serialiser
   mac_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .grp_word  (grp_word),
      .grp_push  (grp_push),
      .grp_space (grp_space),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/mac_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mac_checker
   import mac_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  event_code,
   input wire logic [1:0]  mode,
   input wire logic        drive_enable,
   input wire logic        last_of_run
);

   logic killed_word;
   logic killed_shown;
   logic armed_word;
   logic armed_shown;
   logic disarm_mid;
   logic timeout_word;

   assign killed_word  = rsp_valid && event_code == EvKilled;
   assign killed_shown = mode == ModeKilled && !drive_enable && last_of_run;
   assign armed_word   = rsp_valid && event_code == EvArmed;
   assign armed_shown  = mode == ModeArmed && last_of_run;
   assign disarm_mid   = rsp_valid && rsp_ready && event_code == EvDisarmed && !last_of_run;
   assign timeout_word = rsp_valid && event_code == EvTimeout;

   // a stalled result word stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a kill is the only result of its event and shows the drive off
   `ASSERT_IMPLY(a_killed_state, clock, reset, killed_word, killed_shown)

   // arming is the only result of its event and shows the drive armed
   `ASSERT_IMPLY(a_armed_state, clock, reset, armed_word, armed_shown)

   // a disarm that is not last comes from the watchdog, so timeout follows
   `ASSERT_NEXT(a_timeout_follows, clock, reset, disarm_mid, timeout_word)

endmodule

bind motor_arming_command_controller_core mac_checker u_mac_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .event_code   (rsp_bus.event_code),
   .mode         (rsp_bus.mode),
   .drive_enable (rsp_bus.drive_enable),
   .last_of_run  (rsp_bus.last_of_run)
);

`default_nettype wire

// ----- test/motor_arming_scoreboard.sv -----
`timescale 1ns / 1ps

module motor_arming_scoreboard
   import mac_pkg::*;
#(
   parameter int LINE_LEN = LineLenDefault
) (
   input  logic clock,
   input  logic reset,
   mac_req_if   req_mon,
   mac_rsp_if   rsp_mon,
   mac_csr_if   csr_mon,
   output int   errors,
   output int   pending
);

   typedef struct packed {
      event_type   code;
      logic [10:0] pulse_width;
      mode_type    mode;
      logic        drive_enable;
      logic        last_of_run;
   } result_word_type;

   // settings as last written
   logic [15:0] timeout_ticks;
   logic [15:0] telemetry_ticks;
   logic [10:0] thr_floor;
   logic [10:0] thr_ceiling;

   // predicted controller state
   mode_type    arm_mode;
   logic [10:0] throttle;
   logic        enable;
   logic [15:0] silent_ticks;
   logic [15:0] telemetry_elapsed;
   int          stored_bytes;
   phase_type   line_phase;
   logic [7:0]  letter;
   logic [10:0] number;

   result_word_type expected_results[$];
   result_word_type event_results[$];
   int              fail_count = 0;

   assign errors = fail_count;

   task automatic report_error(input string msg);
      fail_count++;
      $display("%0t: %s", $time, msg);
   endtask

   // raise to the floor first, then cut to the ceiling
   function automatic logic [10:0] limit_throttle(input logic [10:0] v);
      logic [10:0] t;
      t = (v < thr_floor) ? thr_floor : v;
      if (t > thr_ceiling) t = thr_ceiling;
      return t;
   endfunction

   function automatic void push_result(input event_type code);
      result_word_type r;
      r.code         = code;
      r.pulse_width  = throttle;
      r.mode         = arm_mode;
      r.drive_enable = enable;
      r.last_of_run  = 1'b0;
      event_results.push_back(r);
   endfunction

   function automatic void disarm_drive();
      arm_mode = ModeDisarmed;
      throttle = limit_throttle(thr_floor);
      push_result(EvDisarmed);
   endfunction

   function automatic void release_kill();
      if (arm_mode == ModeKilled) begin
         enable = 1'b1;
         disarm_drive();
      end
   endfunction

   function automatic void clear_line();
      stored_bytes = 0;
      line_phase   = PhaseBlank;
      letter       = '0;
      number       = '0;
   endfunction

   // newline: act on the letter gathered so far
   function automatic void run_command();
      if (line_phase == PhaseBlank) return;
      case (letter)
         ChA: begin
            if (arm_mode != ModeKilled) begin
               arm_mode     = ModeArmed;
               silent_ticks = '0;
               throttle     = limit_throttle(thr_floor);
               push_result(EvArmed);
            end
         end
         ChD: disarm_drive();
         ChS: begin
            if (arm_mode == ModeArmed) begin
               throttle     = limit_throttle(number);
               silent_ticks = '0;
            end
         end
         ChR: release_kill();
         default: ;
      endcase
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      int v;
      if (b == ChNl) begin
         run_command();
         clear_line();
      end else if (stored_bytes >= LINE_LEN - 1) begin
         // line full: drop the byte and start over
         clear_line();
      end else begin
         stored_bytes++;
         if (line_phase == PhaseBlank) begin
            if (b != ChSpace && b != ChCr) begin
               letter     = b;
               line_phase = (b == ChS) ? PhaseDigits : PhaseIgnore;
            end
         end else if (line_phase == PhaseDigits) begin
            if (b >= ChZero && b <= ChNine) begin
               v      = int'(number) * 10 + int'(b) - int'(ChZero);
               number = (v > 2047) ? ThrottleSat : 11'(v);
            end else begin
               line_phase = PhaseIgnore;
            end
         end
      end
   endfunction

   // millisecond tick: silence watchdog, then telemetry timer
   function automatic void take_tick();
      if (arm_mode == ModeArmed) begin
         if (silent_ticks != CountSat) silent_ticks++;
         if (silent_ticks > timeout_ticks) begin
            disarm_drive();
            push_result(EvTimeout);
         end
      end
      if (telemetry_elapsed != CountSat) telemetry_elapsed++;
      if (telemetry_elapsed >= telemetry_ticks) begin
         telemetry_elapsed = '0;
         push_result(EvTelemetry);
      end
   endfunction

   function automatic void take_button();
      if (arm_mode == ModeKilled) begin
         release_kill();
      end else begin
         arm_mode = ModeKilled;
         throttle = limit_throttle(thr_floor);
         enable   = 1'b0;
         push_result(EvKilled);
      end
   endfunction

   // work out every result of one request word and queue them
   function automatic void predict_event(input logic [1:0] kind, input logic [7:0] b);
      result_word_type r;
      event_results.delete();
      case (kind)
         CmdByte:   take_byte(b);
         CmdTick:   take_tick();
         CmdButton: take_button();
         default:   ;
      endcase
      for (int i = 0; i < event_results.size(); i++) begin
         r             = event_results[i];
         r.last_of_run = (i == event_results.size() - 1);
         expected_results.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         timeout_ticks     = TimeoutReset;
         telemetry_ticks   = TelemetryReset;
         thr_floor         = ThrMinReset;
         thr_ceiling       = ThrMaxReset;
         arm_mode          = ModeDisarmed;
         throttle          = ThrottleReset;
         enable            = 1'b1;
         silent_ticks      = '0;
         telemetry_elapsed = '0;
         clear_line();
         expected_results.delete();
      end else begin
         // result words against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_error($sformatf("result word with none expected, event_code %0d",
                                      rsp_mon.event_code));
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.event_code !== want.code)
                  report_error($sformatf("event_code %0d, expected %0d",
                                         rsp_mon.event_code, want.code));
               if (rsp_mon.pulse_width !== want.pulse_width)
                  report_error($sformatf("pulse_width %0d, expected %0d",
                                         rsp_mon.pulse_width, want.pulse_width));
               if (rsp_mon.mode !== want.mode)
                  report_error($sformatf("mode %0d, expected %0d", rsp_mon.mode, want.mode));
               if (rsp_mon.drive_enable !== want.drive_enable)
                  report_error($sformatf("drive_enable %0d, expected %0d",
                                         rsp_mon.drive_enable, want.drive_enable));
               if (rsp_mon.last_of_run !== want.last_of_run)
                  report_error($sformatf("last_of_run %0d, expected %0d",
                                         rsp_mon.last_of_run, want.last_of_run));
            end
         end
         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CsrTimeout:   timeout_ticks   = csr_mon.data;
               CsrTelemetry: telemetry_ticks = csr_mon.data;
               CsrThrMin:    thr_floor       = csr_mon.data[10:0];
               CsrThrMax:    thr_ceiling     = csr_mon.data[10:0];
               default:      ;
            endcase
         end
         // request words
         if (req_mon.valid && req_mon.ready) predict_event(req_mon.cmd, req_mon.rx_byte);
      end
      pending <= expected_results.size();
   end

endmodule

// ----- test/tb_motor_arming_command_controller_core.sv -----
`timescale 1ns / 1ps

module tb_motor_arming_command_controller_core;
   import mac_pkg::*;

   localparam logic [1:0] CmdUnused = 2'd3;
   localparam int QuietLimit   = 1000;
   localparam int SettleCycles = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   words_sent     = 0;
   int   quiet_cycles   = 0;
   int   fail_count;
   int   pending_results;

   mac_req_if req_if ();
   mac_rsp_if rsp_if ();
   mac_csr_if csr_if ();

   motor_arming_command_controller_core #(.LINE_LEN(LineLenDefault)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   motor_arming_scoreboard #(.LINE_LEN(LineLenDefault)) score (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_if),
      .rsp_mon (rsp_if),
      .csr_mon (csr_if),
      .errors  (fail_count),
      .pending (pending_results)
   );

   always #5 clock = ~clock;

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // give up when no word moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [1:0] kind, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= kind;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      if (kind != CmdUnused) words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(CmdByte, s[i]);
   endtask

   // stop sending and let every outstanding result drain
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // throttle words carry random upper bits, which must be ignored
   task automatic apply_settings(input logic [15:0] timeout_ms, input logic [15:0] period,
                                 input logic [10:0] lo, input logic [10:0] hi);
      wait_idle();
      write_reg(CsrTimeout, timeout_ms);
      write_reg(CsrTelemetry, period);
      write_reg(CsrThrMin, {5'($urandom), lo});
      write_reg(CsrThrMax, {5'($urandom), hi});
      csr_if.valid <= 1'b0;
   endtask

   // command line: optional blanks, a command letter, digits after S, at times a random byte
   task automatic send_command_line();
      logic [7:0] cmd_char;
      repeat ($urandom_range(0, 2))
         send_word(CmdByte, ($urandom_range(1) != 0) ? ChSpace : ChCr);
      case ($urandom_range(5))
         0, 1:    cmd_char = ChA;
         2:       cmd_char = ChD;
         3, 4:    cmd_char = ChS;
         default: cmd_char = ChR;
      endcase
      send_word(CmdByte, cmd_char);
      if (cmd_char == ChS)
         repeat ($urandom_range(0, 4)) send_word(CmdByte, ChZero + 8'($urandom_range(9)));
      if ($urandom_range(5) == 0) send_word(CmdByte, 8'($urandom));
      send_word(CmdByte, ChNl);
   endtask

   task automatic send_random_burst();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_command_line();
      end else if (pick < 72) begin
         repeat ($urandom_range(1, 6)) send_word(CmdTick, 8'($urandom));
      end else if (pick < 78) begin
         send_word(CmdButton, 8'($urandom));
      end else if (pick < 88) begin
         // raw noise bytes
         repeat ($urandom_range(1, 5)) send_word(CmdByte, 8'($urandom));
         if ($urandom_range(1) != 0) send_word(CmdByte, ChNl);
      end else if (pick < 95) begin
         // line around the storage limit
         n = $urandom_range(LineLenDefault - 3, LineLenDefault + 3);
         send_word(CmdByte, ($urandom_range(1) != 0) ? ChS : ChA);
         for (int i = 1; i < n; i++)
            send_word(CmdByte, ($urandom_range(3) == 0) ? 8'($urandom)
                                                        : ChZero + 8'($urandom_range(9)));
         send_word(CmdByte, ChNl);
      end else begin
         send_word(CmdUnused, 8'($urandom));
      end
   endtask

   initial begin
      int target;
      req_if.valid   = 1'b0;
      req_if.cmd     = CmdByte;
      req_if.rx_byte = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CsrTimeout;
      csr_if.data    = '0;
      rsp_if.ready   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: kill, blocked arm, release, blanks, saturation, timeout with telemetry
      apply_settings(16'd2, 16'd3, 11'd0, 11'd2047);
      send_word(CmdButton, 8'h00);
      send_text("A\n");
      send_text("R\n");
      send_text(" \rA\n");
      send_text("S9999\n");
      send_text("S\n");
      repeat (3) send_word(CmdTick, 8'hFF);
      send_text("D\n");
      send_word(CmdUnused, 8'hFF);
      send_word(CmdByte, 8'h00);
      send_word(CmdByte, ChNl);

      // random rounds, each under its own settings and idling
      for (int round = 0; round < 8; round++) begin
         case (round % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         case (round)
            0: apply_settings(16'd1, 16'd1, 11'd0, 11'd2047);
            1: apply_settings(16'd65535, 16'd65535, 11'd2047, 11'd0);
            2: apply_settings(16'd5, 16'd7, 11'd1000, 11'd2000);
            3: apply_settings(16'd20, 16'd13, 11'd1500, 11'd1200);
            default: apply_settings(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                                    11'($urandom_range(0, 2047)),
                                    11'($urandom_range(0, 2047)));
         endcase
         target = words_sent + 22;
         while (words_sent < target) send_random_burst();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
